// ----- rtl/snb_pkg.sv -----
// Shared types, constants and the sigmoid table of the sigmoid neuron barrier.
package snb_pkg;

  localparam int MODE_W   = 1;
  localparam int IDX_W    = 4;
  localparam int VALUE_W  = 16;
  localparam int ACT_W    = 13;
  localparam int NUM_IN_W = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam int MAX_INPUTS_DEF = 16;

  localparam logic [NUM_IN_W-1:0] NUM_INPUTS_RST = 5'd1;
  localparam logic [0:0] REG_NUM_INPUTS = 1'b0;

  localparam logic [MODE_W-1:0] MODE_SIGNAL = 1'b0;
  localparam logic [MODE_W-1:0] MODE_WEIGHT = 1'b1;

  // 1.0 in unsigned Q1.12.
  localparam logic [ACT_W-1:0] ONE_Q12 = 13'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_SHAPE,
    ST_MUL,
    ST_ROUND,
    ST_EMIT
  } snb_state_t;

  // round(4096 * sigmoid(k/4)) for k = 0..32.
  function automatic logic [11:0] sig_tab(input logic [5:0] k);
    logic [11:0] t;
    case (k)
      6'd0:  t = 12'd2048;
      6'd1:  t = 12'd2303;
      6'd2:  t = 12'd2550;
      6'd3:  t = 12'd2782;
      6'd4:  t = 12'd2994;
      6'd5:  t = 12'd3184;
      6'd6:  t = 12'd3349;
      6'd7:  t = 12'd3490;
      6'd8:  t = 12'd3608;
      6'd9:  t = 12'd3705;
      6'd10: t = 12'd3785;
      6'd11: t = 12'd3850;
      6'd12: t = 12'd3902;
      6'd13: t = 12'd3943;
      6'd14: t = 12'd3976;
      6'd15: t = 12'd4002;
      6'd16: t = 12'd4022;
      6'd17: t = 12'd4038;
      6'd18: t = 12'd4051;
      6'd19: t = 12'd4061;
      6'd20: t = 12'd4069;
      6'd21: t = 12'd4075;
      6'd22: t = 12'd4079;
      6'd23: t = 12'd4083;
      6'd24: t = 12'd4086;
      6'd25: t = 12'd4088;
      6'd26: t = 12'd4090;
      6'd27: t = 12'd4091;
      6'd28: t = 12'd4092;
      6'd29: t = 12'd4093;
      6'd30: t = 12'd4094;
      6'd31: t = 12'd4094;
      default: t = 12'd4095;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/snb_if.sv -----
// Valid/ready channel interfaces for the input items and the results.
interface snb_item_if
  import snb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [IDX_W-1:0]   sender_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output sender_index, output value,
                  input ready);
  modport sink   (input valid, input mode, input sender_index, input value,
                  output ready);
endinterface

interface snb_result_if
  import snb_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] activation;

  modport source (output valid, output activation, input ready);
  modport sink   (input valid, input activation, output ready);
endinterface

// ----- rtl/sigmoid_neuron_barrier_core.sv -----
// Top level of the sigmoid neuron barrier: slot memories, MAC walk and sigmoid.
//
// One neuron with MAX_INPUTS input slots. A weight beat (mode 1) writes the
// weight of one slot; a signal beat (mode 0) overwrites the slot's signal and
// counts one receipt, duplicates included. When the count reaches num_inputs
// (zero is taken as one) the neuron fires: it sums signal times weight over
// all MAX_INPUTS slots exactly, applies a 33-entry interpolated sigmoid to
// the sum of Q4.12 products that saturates at plus or minus 8 and beyond,
// and delivers one activation beat in unsigned Q1.12 (4096 is 1.0). Slots
// at or above MAX_INPUTS are ignored. A beat that does not fire leaves the
// input ready; a firing beat holds it off until its activation is loaded:
// the weight and signal memories share one read address, so the walk does
// one multiply-accumulate per slot per cycle, followed by a pipeline drain,
// the sigmoid states SHAPE, MUL and ROUND, and the load of the output
// register, which waits until the previous activation is taken. The output
// register lets new weight and signal beats come in while an activation
// waits. Both memories reset to zero through a valid bit per entry, so no
// clearing pass is needed. num_inputs sits at byte address 0 of the APB port.
module sigmoid_neuron_barrier_core
  import snb_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  snb_item_if.sink          item,
  snb_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int ADDR_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  // Products are at most 2^30 in magnitude; the sum grows by log2 of the slots.
  localparam int ACC_W  = 33 + $clog2(MAX_INPUTS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_INPUTS - 1);

  snb_state_t state, state_next;

  // Configuration.
  logic [NUM_IN_W-1:0] num_inputs;
  logic                cfg_wr;
  logic                cfg_hit;

  // Slot memories with valid bits that stand in for their all-zero reset.
  logic [VALUE_W-1:0] sig_mem [MAX_INPUTS];
  logic [VALUE_W-1:0] wt_mem  [MAX_INPUTS];
  logic [MAX_INPUTS-1:0] sig_ok;
  logic [MAX_INPUTS-1:0] wt_ok;

  // Item decode.
  logic                item_acc;
  logic                slot_in_range;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_sig;
  logic                wr_wt;
  logic [NUM_IN_W-1:0] receipt_count;
  logic [NUM_IN_W-1:0] count_inc;
  logic [NUM_IN_W-1:0] threshold;
  logic                fire;

  // Walk pipeline.
  logic [ADDR_W-1:0]         walk_addr;
  logic                      walk_last;
  logic                      rd_en;
  logic                      rd_vld;
  logic [VALUE_W-1:0]        rd_sig_raw;
  logic [VALUE_W-1:0]        rd_wt_raw;
  logic                      rd_sig_ok;
  logic                      rd_wt_ok;
  logic signed [VALUE_W-1:0] rd_sig;
  logic signed [VALUE_W-1:0] rd_wt;
  logic signed [31:0]        prod;
  logic                      prod_vld;
  logic signed [ACC_W-1:0]   acc;

  // Sigmoid stages.
  logic [ACC_W-1:0] mag;
  logic [4:0]       seg;
  logic [11:0]      t_lo;
  logic [11:0]      t_hi;
  logic             neg;
  logic             sat;
  logic [21:0]      frac;
  logic [11:0]      base;
  logic [7:0]       slope;
  logic [29:0]      interp;
  logic [30:0]      interp_rnd;
  logic [ACT_W-1:0] y;
  logic [ACT_W-1:0] act_val;
  logic [ACT_W-1:0] act;

  // Output register.
  logic             out_valid;
  logic [ACT_W-1:0] out_act;
  logic             out_free;
  logic             load_out;

  // ---------------------------------------------------------------------
  // APB register: only num_inputs, at register index 0 of paddr[2].
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_NUM_INPUTS);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? CFG_DW'(num_inputs) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_inputs <= NUM_INPUTS_RST;
    end else if (cfg_wr) begin
      num_inputs <= pwdata[NUM_IN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Item decode. Out-of-range slots are taken and then dropped silently.
  // ---------------------------------------------------------------------
  assign item_acc      = item.valid && item.ready;
  assign slot_in_range = (9'(item.sender_index) < 9'(MAX_INPUTS));
  assign wr_addr       = ADDR_W'(item.sender_index);
  assign wr_sig        = item_acc && slot_in_range && (item.mode == MODE_SIGNAL);
  assign wr_wt         = item_acc && slot_in_range && (item.mode == MODE_WEIGHT);
  assign count_inc     = receipt_count + 5'd1;
  assign threshold     = (num_inputs == '0) ? 5'd1 : num_inputs;
  assign fire          = wr_sig && (count_inc >= threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      receipt_count <= '0;
    end else if (wr_sig) begin
      receipt_count <= fire ? '0 : count_inc;
    end
  end

  // ---------------------------------------------------------------------
  // Slot memories. Writes come only from accepted items in the idle state
  // and reads only during the walk, so the two never meet on one entry in
  // the same cycle; a read in the cycle after a write sees the new data.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_sig) begin
      sig_mem[wr_addr] <= item.value;
    end
    if (wr_wt) begin
      wt_mem[wr_addr] <= item.value;
    end
    if (rd_en) begin
      rd_sig_raw <= sig_mem[walk_addr];
      rd_wt_raw  <= wt_mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_ok    <= '0;
      wt_ok     <= '0;
      rd_sig_ok <= 1'b0;
      rd_wt_ok  <= 1'b0;
    end else begin
      if (wr_sig) begin
        sig_ok[wr_addr] <= 1'b1;
      end
      if (wr_wt) begin
        wt_ok[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_sig_ok <= sig_ok[walk_addr];
        rd_wt_ok  <= wt_ok[walk_addr];
      end
    end
  end

  // An entry never written reads as its reset value of zero.
  assign rd_sig = rd_sig_ok ? $signed(rd_sig_raw) : '0;
  assign rd_wt  = rd_wt_ok  ? $signed(rd_wt_raw)  : '0;

  // ---------------------------------------------------------------------
  // Walk: address, registered read, registered product, accumulate.
  // ---------------------------------------------------------------------
  assign walk_last = (walk_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_addr <= '0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      prod_vld <= rd_vld;
      if (fire) begin
        walk_addr <= '0;
      end else if (rd_en && !walk_last) begin
        walk_addr <= walk_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= rd_sig * rd_wt;
    end
    if (fire) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // ---------------------------------------------------------------------
  // Sigmoid: magnitude and table lookup, interpolation product, rounding
  // and sign fold. Magnitudes of 8.0 and above saturate.
  // ---------------------------------------------------------------------
  assign mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign seg  = mag[26:22];
  assign t_lo = sig_tab({1'b0, seg});
  assign t_hi = sig_tab({1'b0, seg} + 6'd1);

  always_ff @(posedge clk) begin
    if (state == ST_SHAPE) begin
      neg   <= acc[ACC_W-1];
      sat   <= |mag[ACC_W-1:27];
      frac  <= mag[21:0];
      base  <= t_lo;
      slope <= 8'(t_hi - t_lo);
    end
    if (state == ST_MUL) begin
      interp <= 30'(slope * frac);
    end
    if (state == ST_ROUND) begin
      act <= act_val;
    end
  end

  assign interp_rnd = {1'b0, interp} + 31'd2097152;
  assign y          = 13'(base) + 13'(interp_rnd[30:22]);

  always_comb begin
    if (sat) begin
      act_val = neg ? '0 : ONE_Q12;
    end else begin
      act_val = neg ? (ONE_Q12 - y) : y;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_act <= act;
    end
  end

  assign result.valid      = out_valid;
  assign result.activation = out_act;

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !prod_vld) begin
          state_next = ST_SHAPE;
        end
      end
      ST_SHAPE: state_next = ST_MUL;
      ST_MUL:   state_next = ST_ROUND;
      ST_ROUND: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: item.ready = 1'b1;
      ST_WALK: rd_en      = 1'b1;
      ST_EMIT: load_out   = out_free;
      default: begin
        item.ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- verif/snb_activation_check.sv -----
// Activation predictor and comparator that watches the sigmoid neuron barrier channels.
`timescale 1ns / 100ps

module snb_activation_check
  import snb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic [MODE_W-1:0]         item_mode,
  input  logic [IDX_W-1:0]          sender_index,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic [ACT_W-1:0]          activation,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [CFG_DW-1:0]         pwdata,
  output int                        pending,
  output int                        mismatches
);

  localparam logic [CFG_AW-1:0] NUM_INPUTS_ADDR = CFG_AW'({REG_NUM_INPUTS, 2'b00});

  // Knots of the interpolated sigmoid: round(4096 * sigmoid(k / 4)) for k = 0..32.
  localparam int unsigned SIGMOID_KNOTS [33] = '{
    2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490,
    3608, 3705, 3785, 3850, 3902, 3943, 3976, 4002,
    4022, 4038, 4051, 4061, 4069, 4075, 4079, 4083,
    4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094,
    4095
  };

  logic signed [VALUE_W-1:0] weights [MAX_INPUTS_DEF];
  logic signed [VALUE_W-1:0] signals [MAX_INPUTS_DEF];
  logic [NUM_IN_W-1:0]       receipts;
  logic [NUM_IN_W-1:0]       num_inputs;
  logic [ACT_W-1:0]          activations_due [$];

  // Sum is Q8.24; magnitudes of 8.0 and above saturate.
  function automatic logic [ACT_W-1:0] sigmoid_of_sum(input longint sum);
    longint unsigned mag;
    longint unsigned seg;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned y;
    mag = (sum < 0) ? -sum : sum;
    if (mag >= (64'd8 << 24)) begin
      return (sum < 0) ? '0 : ONE_Q12;
    end
    seg  = mag >> 22;
    frac = mag & ((64'd1 << 22) - 1);
    lo   = SIGMOID_KNOTS[seg];
    hi   = SIGMOID_KNOTS[seg + 1];
    y    = lo + (((hi - lo) * frac + (64'd1 << 21)) >> 22);
    return (sum < 0) ? ONE_Q12 - y[ACT_W-1:0] : y[ACT_W-1:0];
  endfunction

  function automatic longint weighted_sum();
    longint acc;
    acc = 0;
    for (int k = 0; k < MAX_INPUTS_DEF; k++) begin
      acc += longint'(signals[k]) * longint'(weights[k]);
    end
    return acc;
  endfunction

  task automatic absorb_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] slot,
                             input logic signed [VALUE_W-1:0] v);
    logic [NUM_IN_W-1:0] threshold;
    threshold = (num_inputs == '0) ? NUM_IN_W'(1) : num_inputs;
    if (m == MODE_WEIGHT) begin
      weights[slot] = v;
    end else begin
      signals[slot] = v;
      receipts      = receipts + 1'b1;
      if (receipts >= threshold) begin
        activations_due.insert(activations_due.size(), sigmoid_of_sum(weighted_sum()));
        receipts = '0;
      end
    end
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_INPUTS_DEF; k++) begin
        weights[k] = '0;
        signals[k] = '0;
      end
      receipts   = '0;
      num_inputs = NUM_INPUTS_RST;
      activations_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (activations_due.size() == 0) begin
          $error("activation beat with nothing expected: actual %0d", activation);
          mismatches++;
        end else begin
          if (activation !== activations_due[0]) begin
            $error("activation mismatch: expected %0d, actual %0d",
                   activations_due[0], activation);
            mismatches++;
          end
          void'(activations_due.pop_front());
        end
      end
      if (psel && penable && pwrite && pready && paddr == NUM_INPUTS_ADDR) begin
        num_inputs = pwdata[NUM_IN_W-1:0];
      end
      if (item_valid && item_ready) begin
        absorb_item(item_mode, sender_index, item_value);
      end
    end
    pending = activations_due.size();
  end

endmodule

// ----- verif/sigmoid_neuron_barrier_core_tb.sv -----
// Stimulus, handshake pacing and verdict for the sigmoid neuron barrier core.
`timescale 1ns / 100ps

module sigmoid_neuron_barrier_core_tb;
  import snb_pkg::*;

  // Byte address of num_inputs on the APB port (register 0, word aligned).
  localparam logic [CFG_AW-1:0] NUM_INPUTS_ADDR = CFG_AW'({REG_NUM_INPUTS, 2'b00});

  // A firing beat holds the input off through the walk, drain and sigmoid; the rest
  // after a drained phase covers that with margin before the threshold is rewritten.
  localparam int SETTLE_CYCLES   = MAX_INPUTS_DEF + 10;
  // Longest correct quiet stretch is a firing walk plus a full receiver stall plus
  // a sender gap plus the settle pause; the watchdog allows many times that.
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_COUNT     = 12;
  localparam int ITEMS_PER_PHASE = 52;

  // Threshold for each random phase. Zero, one, the slot count and the register
  // maximum (only reachable through duplicate receipts) all appear.
  localparam logic [NUM_IN_W-1:0] PHASE_THRESHOLDS [PHASE_COUNT] = '{
    5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd2, 5'd31, 5'd5, 5'd16, 5'd12, 5'd3, 5'd1
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Pacing switches, changed per phase by the stimulus process.
  logic sender_gaps;
  logic sink_stalls;

  int pending;
  int mismatches;
  int stalled_cycles;

  snb_item_if   item_ch ();
  snb_result_if result_ch ();

  sigmoid_neuron_barrier_core dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  snb_activation_check chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_ch.valid),
    .item_ready   (item_ch.ready),
    .item_mode    (item_ch.mode),
    .sender_index (item_ch.sender_index),
    .item_value   (item_ch.value),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .activation   (result_ch.activation),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pending      (pending),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Value mix for random beats. Products of full-range Q4.12 values nearly always
  // saturate, so most values are kept within plus or minus 1.0 or smaller to land
  // sums on the interpolated part of the curve. Full-range draws make sure every
  // bit of the field toggles, and a handful of corner values is mixed in.
  function automatic logic [VALUE_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 8192)) - 4096;
      4, 5:       v = int'($urandom_range(0, 1024)) - 512;
      6: begin
        case ($urandom_range(0, 6))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 0;
          3:       v = 16'hFFFF;
          4:       v = 1;
          5:       v = 16'h1000;
          default: v = 16'hF000;
        endcase
      end
      default:    v = int'($urandom());
    endcase
    return v[VALUE_W-1:0];
  endfunction

  // Presents one beat and returns at the edge that accepts it. Ready is sampled
  // on the falling edge so the decision never depends on event order at the
  // rising edge.
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] slot,
                           input logic [VALUE_W-1:0] v);
    logic taken;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= m;
    item_ch.sender_index <= slot;
    item_ch.value        <= v;
    do begin
      @(negedge clk);
      taken = item_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // APB write of num_inputs in a setup and an access phase. Bits above the register
  // width carry random junk, which the block is expected to drop.
  task automatic write_num_inputs(input logic [NUM_IN_W-1:0] n);
    logic [CFG_DW-1:0] word;
    logic              taken;
    word                 = $urandom();
    word[NUM_IN_W-1:0]   = n;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_INPUTS_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      taken = pready;
      @(posedge clk);
    end while (!taken);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending, waits for every predicted activation to be taken, then lets
  // the block finish any walk before the next threshold write.
  task automatic drain_and_rest();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: ready runs in random stretches, broken by stall bursts while
  // stalls are enabled for the phase.
  initial begin
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (sink_stalls && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: any accepted beat or APB access counts as progress.
  initial stalled_cycles = 0;

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    item_ch.valid        = 1'b0;
    item_ch.mode         = MODE_SIGNAL;
    item_ch.sender_index = '0;
    item_ch.value        = '0;
    sender_gaps          = 1'b1;
    sink_stalls          = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, threshold at its reset value of one. With every weight
    // still zero the first signal must give exactly one half.
    send_item(MODE_SIGNAL, 4'd0, 16'h1000);
    // Weight 1.0 on slot 0, then signals on both sides of zero on the table.
    send_item(MODE_WEIGHT, 4'd0, 16'h1000);
    send_item(MODE_SIGNAL, 4'd0, 16'h0800);
    send_item(MODE_SIGNAL, 4'd0, 16'hF800);
    // Just under +8.0 lands on the last table segment; exactly -8.0 saturates.
    send_item(MODE_SIGNAL, 4'd0, 16'h7FFF);
    send_item(MODE_SIGNAL, 4'd0, 16'h8000);
    // Most negative weight against both extreme signals: deep saturation.
    send_item(MODE_WEIGHT, 4'd0, 16'h8000);
    send_item(MODE_SIGNAL, 4'd0, 16'h8000);
    send_item(MODE_SIGNAL, 4'd0, 16'h7FFF);
    // Slot 15 fires once on its own signal, yet its stored pair must still
    // enter the sum when slot 7 fires with slot 0 weighted out.
    send_item(MODE_WEIGHT, 4'd15, 16'h7FFF);
    send_item(MODE_SIGNAL, 4'd15, 16'h0001);
    send_item(MODE_WEIGHT, 4'd0, 16'h0000);
    send_item(MODE_SIGNAL, 4'd7, 16'h0000);
    drain_and_rest();

    // A zero threshold behaves as one.
    write_num_inputs(5'd0);
    send_item(MODE_SIGNAL, 4'd3, 16'h4000);
    drain_and_rest();

    // Duplicate receipts from one slot still count toward the threshold.
    write_num_inputs(5'd3);
    send_item(MODE_SIGNAL, 4'd5, 16'h0400);
    send_item(MODE_SIGNAL, 4'd5, 16'hFC00);
    send_item(MODE_SIGNAL, 4'd5, 16'h2000);
    drain_and_rest();

    // Lowering the threshold below the count already held: the next signal fires.
    write_num_inputs(5'd4);
    send_item(MODE_SIGNAL, 4'd2, 16'h0123);
    send_item(MODE_SIGNAL, 4'd9, 16'hFEDC);
    drain_and_rest();
    write_num_inputs(5'd1);
    send_item(MODE_SIGNAL, 4'd4, 16'h0FFF);
    drain_and_rest();

    // Random phases, one threshold each. The last two run with no gaps or stalls.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      sender_gaps = (p < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
      sink_stalls = (p < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
      write_num_inputs(PHASE_THRESHOLDS[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(($urandom_range(0, 3) == 0) ? MODE_WEIGHT : MODE_SIGNAL,
                  IDX_W'($urandom_range(0, MAX_INPUTS_DEF - 1)), pick_value());
      end
      drain_and_rest();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
